/* src/lbab_pkg.sv */
// ============================================================================
// lbab_pkg - shared types and constants of the letterbox bar alpha blend
// Field widths, register indexes and the configuration record.
// ============================================================================
package lbab_pkg;

	// Width of the row number of a pixel.
	localparam int ROW_BITS = 12;

	// Configuration register widths.
	localparam int FH_BITS = 13;
	localparam int SS_BITS = 17;
	localparam int SC_BITS = 32;
	localparam int CH_BITS = 8;

	// Configuration port.
	localparam int WR_INDEX_BITS = 2;
	localparam int WR_DATA_BITS  = 32;

	localparam logic [WR_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 2'd0;
	localparam logic [WR_INDEX_BITS-1:0] REG_STRIP_SIZE   = 2'd1;
	localparam logic [WR_INDEX_BITS-1:0] REG_STRIP_COLOR  = 2'd2;

	// Register values after reset.
	localparam logic [FH_BITS-1:0] FRAME_HEIGHT_RST = 13'd480;
	localparam logic [SS_BITS-1:0] STRIP_SIZE_RST   = 17'd32768;
	localparam logic [SC_BITS-1:0] STRIP_COLOR_RST  = 32'hFF00_0000;

	// Fixed-point scale of the strip size: one is 2**FX_SHIFT.
	localparam int FX_SHIFT = 16;
	localparam logic [SS_BITS:0] ONE_FX = 18'h1_0000;

	// Center row, distance and comparison widths.
	localparam int C_BITS    = FH_BITS - 1;
	localparam int DIST_BITS = (ROW_BITS > C_BITS) ? ROW_BITS : C_BITS;
	localparam int LHS_BITS  = SS_BITS + 1 + C_BITS + 1;
	localparam int RHS_BITS  = DIST_BITS + FX_SHIFT;
	localparam int CMP_BITS  = (LHS_BITS > RHS_BITS + 1) ? LHS_BITS : RHS_BITS + 1;

	// Blend numerator width: p*(255-A) + A*s stays below 2**16.
	localparam int NUM_BITS = 2 * CH_BITS;
	localparam logic [CH_BITS-1:0] CH_MAX = 8'd255;

	typedef struct packed {
		logic [FH_BITS-1:0] frame_height;
		logic [SS_BITS-1:0] strip_size;
		logic [SC_BITS-1:0] strip_color;
	} cfg_t;

endpackage

/* src/letterbox_bar_alpha_blend.sv */
// ============================================================================
// letterbox_bar_alpha_blend - letterbox bars blended over a pixel stream
// Pixels near the center row pass; the rest are blended toward the strip.
// ============================================================================
// The block takes one pixel request in every clock cycle: busy is always
// low, so start may stay high for a whole frame. The result of a request
// passes the three register stages of the path: the input register, the
// stage that holds the threshold product and the blend numerators, and the
// result register. It is marked by done for exactly one cycle; the
// receiver cannot stall, so it must take every result as it comes.
// Configuration writes take effect at once and should be made only while
// no request is in flight.
module letterbox_bar_alpha_blend (
	input  logic                               clk,
	input  logic                               arst_n,

	input  logic                               wr_en,
	input  logic [lbab_pkg::WR_INDEX_BITS-1:0] wr_index,
	input  logic [lbab_pkg::WR_DATA_BITS-1:0]  wr_data,

	input  logic                               start,
	output logic                               busy,
	input  logic [lbab_pkg::ROW_BITS-1:0]      row,
	input  logic [lbab_pkg::CH_BITS-1:0]       pix_alpha,
	input  logic [lbab_pkg::CH_BITS-1:0]       pix_red,
	input  logic [lbab_pkg::CH_BITS-1:0]       pix_green,
	input  logic [lbab_pkg::CH_BITS-1:0]       pix_blue,

	output logic                               done,
	output logic [lbab_pkg::CH_BITS-1:0]       out_alpha,
	output logic [lbab_pkg::CH_BITS-1:0]       out_red,
	output logic [lbab_pkg::CH_BITS-1:0]       out_green,
	output logic [lbab_pkg::CH_BITS-1:0]       out_blue
);

	lbab_pkg::cfg_t cfg_q;

	logic                             accept;
	logic                             valid_s1;
	logic                             valid_s2;
	logic                             done_s3;
	logic [lbab_pkg::ROW_BITS-1:0]    row_s1;
	logic [lbab_pkg::CH_BITS-1:0]     alpha_s1;
	logic [lbab_pkg::CH_BITS-1:0]     red_s1;
	logic [lbab_pkg::CH_BITS-1:0]     green_s1;
	logic [lbab_pkg::CH_BITS-1:0]     blue_s1;
	logic [lbab_pkg::CH_BITS-1:0]     alpha_s2;
	logic [lbab_pkg::CH_BITS-1:0]     red_s2;
	logic [lbab_pkg::CH_BITS-1:0]     green_s2;
	logic [lbab_pkg::CH_BITS-1:0]     blue_s2;
	logic [lbab_pkg::CH_BITS-1:0]     red_bl_s2;
	logic [lbab_pkg::CH_BITS-1:0]     green_bl_s2;
	logic [lbab_pkg::CH_BITS-1:0]     blue_bl_s2;
	logic                             pass_s2;
	logic [lbab_pkg::CH_BITS-1:0]     alpha_s3;
	logic [lbab_pkg::CH_BITS-1:0]     red_s3;
	logic [lbab_pkg::CH_BITS-1:0]     green_s3;
	logic [lbab_pkg::CH_BITS-1:0]     blue_s3;
	logic [lbab_pkg::CH_BITS-1:0]     strip_alpha;
	logic [lbab_pkg::CH_BITS-1:0]     strip_red;
	logic [lbab_pkg::CH_BITS-1:0]     strip_green;
	logic [lbab_pkg::CH_BITS-1:0]     strip_blue;

	// The pipeline never stalls, so every request is taken.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Configuration registers. Writes to an unused index are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_height <= lbab_pkg::FRAME_HEIGHT_RST;
			cfg_q.strip_size   <= lbab_pkg::STRIP_SIZE_RST;
			cfg_q.strip_color  <= lbab_pkg::STRIP_COLOR_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				lbab_pkg::REG_FRAME_HEIGHT: begin
					cfg_q.frame_height <= wr_data[lbab_pkg::FH_BITS-1:0];
				end
				lbab_pkg::REG_STRIP_SIZE: begin
					cfg_q.strip_size <= wr_data[lbab_pkg::SS_BITS-1:0];
				end
				lbab_pkg::REG_STRIP_COLOR: begin
					cfg_q.strip_color <= wr_data[lbab_pkg::SC_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign strip_alpha = cfg_q.strip_color[31:24];
	assign strip_red   = cfg_q.strip_color[23:16];
	assign strip_green = cfg_q.strip_color[15:8];
	assign strip_blue  = cfg_q.strip_color[7:0];

	// Valid bits of the three stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			done_s3  <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			done_s3  <= valid_s2;
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (accept) begin
			row_s1   <= row;
			alpha_s1 <= pix_alpha;
			red_s1   <= pix_red;
			green_s1 <= pix_green;
			blue_s1  <= pix_blue;
		end
	end

	// The original pixel travels alongside the blend for the pass case.
	always_ff @(posedge clk) begin
		alpha_s2 <= alpha_s1;
		red_s2   <= red_s1;
		green_s2 <= green_s1;
		blue_s2  <= blue_s1;
	end

	lbab_bar_test u_bar_test (
		.clk     (clk),
		.row_s1  (row_s1),
		.cfg     (cfg_q),
		.pass_s2 (pass_s2)
	);

	lbab_blend_ch u_blend_red (
		.clk         (clk),
		.pix_s1      (red_s1),
		.strip       (strip_red),
		.strip_alpha (strip_alpha),
		.blend_s2    (red_bl_s2)
	);

	lbab_blend_ch u_blend_green (
		.clk         (clk),
		.pix_s1      (green_s1),
		.strip       (strip_green),
		.strip_alpha (strip_alpha),
		.blend_s2    (green_bl_s2)
	);

	lbab_blend_ch u_blend_blue (
		.clk         (clk),
		.pix_s1      (blue_s1),
		.strip       (strip_blue),
		.strip_alpha (strip_alpha),
		.blend_s2    (blue_bl_s2)
	);

	// Result register: pass the pixel between the bars, blend it elsewhere.
	always_ff @(posedge clk) begin
		alpha_s3 <= alpha_s2;
		red_s3   <= pass_s2 ? red_s2   : red_bl_s2;
		green_s3 <= pass_s2 ? green_s2 : green_bl_s2;
		blue_s3  <= pass_s2 ? blue_s2  : blue_bl_s2;
	end

	assign done      = done_s3;
	assign out_alpha = alpha_s3;
	assign out_red   = red_s3;
	assign out_green = green_s3;
	assign out_blue  = blue_s3;

	// Every result stems from an accepted request.
	a_done_has_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 3))
		else $error("result without a matching request");

	// Every accepted request yields a result.
	a_request_has_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("request lost in the pipeline");

	// The pixel's own alpha comes through untouched.
	a_alpha_kept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (out_alpha == $past(pix_alpha, 3)))
		else $error("output alpha differs from input alpha");

	// A fully transparent strip leaves the color unchanged.
	a_clear_strip: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ($past(cfg_q.strip_color[31:24], 2) == 8'd0))
		|-> (out_red == $past(pix_red, 3)))
		else $error("transparent strip changed the pixel");

	// With center row zero and an opaque strip, the strip color is shown.
	a_opaque_strip: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ($past(cfg_q.strip_color[31:24], 2) == 8'hFF)
		 && ($past(cfg_q.frame_height, 2) < 13'd2))
		|-> (out_green == $past(cfg_q.strip_color[15:8], 2)))
		else $error("opaque strip not shown");

endmodule

/* src/lbab_bar_test.sv */
// ============================================================================
// lbab_bar_test - decides whether a row lies between the bars
// Registers the threshold product and the scaled distance, then compares.
// ============================================================================
module lbab_bar_test (
	input  logic                          clk,
	input  logic [lbab_pkg::ROW_BITS-1:0] row_s1,
	input  lbab_pkg::cfg_t                cfg,
	output logic                          pass_s2
);

	logic [lbab_pkg::C_BITS-1:0]           center;
	logic [lbab_pkg::DIST_BITS-1:0]        row_ext;
	logic [lbab_pkg::DIST_BITS-1:0]        center_ext;
	logic signed [lbab_pkg::DIST_BITS:0]   diff;
	logic [lbab_pkg::DIST_BITS-1:0]        row_dist;
	logic signed [lbab_pkg::SS_BITS:0]     one_minus;
	logic signed [lbab_pkg::LHS_BITS-1:0]  lhs_d;
	logic signed [lbab_pkg::LHS_BITS-1:0]  lhs_s2;
	logic [lbab_pkg::RHS_BITS-1:0]         rhs_s2;
	logic signed [lbab_pkg::CMP_BITS-1:0]  lhs_cmp;
	logic signed [lbab_pkg::CMP_BITS-1:0]  rhs_cmp;

	assign center     = cfg.frame_height[lbab_pkg::FH_BITS-1:1];
	assign row_ext    = lbab_pkg::DIST_BITS'(row_s1);
	assign center_ext = lbab_pkg::DIST_BITS'(center);

	// Absolute distance of the row from the center row.
	assign diff = $signed({1'b0, row_ext}) - $signed({1'b0, center_ext});
	assign row_dist = diff[lbab_pkg::DIST_BITS] ? lbab_pkg::DIST_BITS'(-diff)
	                                            : lbab_pkg::DIST_BITS'(diff);

	// Negative when the strip size exceeds one, which forces a blend.
	assign one_minus = $signed(lbab_pkg::ONE_FX - {1'b0, cfg.strip_size});
	assign lhs_d     = one_minus * $signed({1'b0, center});

	always_ff @(posedge clk) begin
		lhs_s2 <= lhs_d;
		rhs_s2 <= {row_dist, lbab_pkg::FX_SHIFT'(0)};
	end

	assign lhs_cmp = lbab_pkg::CMP_BITS'(lhs_s2);
	assign rhs_cmp = $signed(lbab_pkg::CMP_BITS'(rhs_s2));
	assign pass_s2 = lhs_cmp > rhs_cmp;

endmodule

/* src/lbab_blend_ch.sv */
// ============================================================================
// lbab_blend_ch - blends one color channel toward the strip color
// Registers p*(255-A) + A*s, then divides by 255 exactly.
// ============================================================================
module lbab_blend_ch (
	input  logic                         clk,
	input  logic [lbab_pkg::CH_BITS-1:0] pix_s1,
	input  logic [lbab_pkg::CH_BITS-1:0] strip,
	input  logic [lbab_pkg::CH_BITS-1:0] strip_alpha,
	output logic [lbab_pkg::CH_BITS-1:0] blend_s2
);

	logic [lbab_pkg::CH_BITS-1:0]  inv_alpha;
	logic [lbab_pkg::NUM_BITS-1:0] num_d;
	logic [lbab_pkg::NUM_BITS-1:0] num_s2;
	logic [lbab_pkg::NUM_BITS:0]   quot;

	assign inv_alpha = lbab_pkg::CH_MAX - strip_alpha;
	assign num_d = {lbab_pkg::CH_BITS'(0), pix_s1} * {lbab_pkg::CH_BITS'(0), inv_alpha}
	             + {lbab_pkg::CH_BITS'(0), strip_alpha} * {lbab_pkg::CH_BITS'(0), strip};

	always_ff @(posedge clk) begin
		num_s2 <= num_d;
	end

	// floor(x/255) equals (x + (x >> 8) + 1) >> 8 for every x up to 255*255, the largest numerator.
	assign quot = {1'b0, num_s2}
	            + (lbab_pkg::NUM_BITS + 1)'(num_s2[lbab_pkg::NUM_BITS-1:lbab_pkg::CH_BITS])
	            + (lbab_pkg::NUM_BITS + 1)'(1);
	assign blend_s2 = quot[lbab_pkg::NUM_BITS-1:lbab_pkg::CH_BITS];

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// ============================================================================
// tb_top - self-checking testbench of the letterbox bar alpha blend
// A short table of directed pixel requests and register writes runs first.
// Random phases follow, each with fresh register settings. Every result is
// compared with a hand-written pixel or an in-bench bar test and blend.
// ============================================================================
module tb_top;

	// One ARGB pixel as it enters or leaves the block.
	typedef struct packed {
		logic [lbab_pkg::CH_BITS-1:0] alpha;
		logic [lbab_pkg::CH_BITS-1:0] red;
		logic [lbab_pkg::CH_BITS-1:0] green;
		logic [lbab_pkg::CH_BITS-1:0] blue;
	} argb_t;

	// One row of the directed table: either a register write or a pixel
	// request. A pixel row may carry a hand-written expected pixel.
	typedef struct packed {
		logic                               is_write;
		logic [lbab_pkg::WR_INDEX_BITS-1:0] index;
		logic [lbab_pkg::WR_DATA_BITS-1:0]  data;
		logic [lbab_pkg::ROW_BITS-1:0]      row;
		argb_t                              pixel;
		logic                               typed;
		argb_t                              want;
	} plan_step_t;

	// The one index of the write port that maps to no register.
	localparam logic [lbab_pkg::WR_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

	localparam int ROW_MAX      = (1 << lbab_pkg::ROW_BITS) - 1;
	localparam int PHASES       = 10;
	localparam int PHASE_PIXELS = 95;
	localparam int TAIL_CYCLES  = 8;
	localparam int STALL_LIMIT  = 1000;
	localparam int SHOWN_ERRORS = 10;

	logic                               clk;
	logic                               arst_n;
	logic                               wr_en;
	logic [lbab_pkg::WR_INDEX_BITS-1:0] wr_index;
	logic [lbab_pkg::WR_DATA_BITS-1:0]  wr_data;
	logic                               start;
	logic                               busy;
	logic [lbab_pkg::ROW_BITS-1:0]      row;
	logic [lbab_pkg::CH_BITS-1:0]       pix_alpha;
	logic [lbab_pkg::CH_BITS-1:0]       pix_red;
	logic [lbab_pkg::CH_BITS-1:0]       pix_green;
	logic [lbab_pkg::CH_BITS-1:0]       pix_blue;
	logic                               done;
	logic [lbab_pkg::CH_BITS-1:0]       out_alpha;
	logic [lbab_pkg::CH_BITS-1:0]       out_red;
	logic [lbab_pkg::CH_BITS-1:0]       out_green;
	logic [lbab_pkg::CH_BITS-1:0]       out_blue;

	// Our copy of the registers, updated at every write we make.
	lbab_pkg::cfg_t live_cfg;
	// Pixels still to come out of the block, oldest first.
	argb_t pending_pixels[$];
	argb_t want_px;
	argb_t got_px;

	int px_sent;
	int px_directed;
	int px_blended;
	int px_passed;
	int writes_done;
	int results_seen;
	int mismatches;
	int stall_cycles;

	letterbox_bar_alpha_blend DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.start     (start),
		.busy      (busy),
		.row       (row),
		.pix_alpha (pix_alpha),
		.pix_red   (pix_red),
		.pix_green (pix_green),
		.pix_blue  (pix_blue),
		.done      (done),
		.out_alpha (out_alpha),
		.out_red   (out_red),
		.out_green (out_green),
		.out_blue  (out_blue)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// ------------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------------

	// A row is in a bar unless (1 - strip_size) * c > d, with c the center
	// row and d the distance from it, all scaled by 2**16 so that the test
	// stays exact. Signed products matter: a strip size above one makes the
	// left side negative, and a zero center row makes it zero.
	function automatic bit falls_in_bar(input logic [lbab_pkg::ROW_BITS-1:0] r);
		longint center;
		longint row_dist;
		longint lhs;
		longint rhs;
		center = longint'(live_cfg.frame_height >> 1);
		row_dist = longint'(r) - center;
		if (row_dist < 0) begin
			row_dist = -row_dist;
		end
		lhs = (longint'(lbab_pkg::ONE_FX) - longint'(live_cfg.strip_size)) * center;
		rhs = longint'(lbab_pkg::ONE_FX) * row_dist;
		return !(lhs > rhs);
	endfunction

	// floor((255*p + A*(s - p)) / 255), rewritten so it never goes negative.
	function automatic logic [lbab_pkg::CH_BITS-1:0] mix_channel(
			input logic [lbab_pkg::CH_BITS-1:0] p,
			input logic [lbab_pkg::CH_BITS-1:0] s,
			input logic [lbab_pkg::CH_BITS-1:0] a);
		int num;
		num = int'(p) * (int'(lbab_pkg::CH_MAX) - int'(a)) + int'(a) * int'(s);
		return lbab_pkg::CH_BITS'(num / int'(lbab_pkg::CH_MAX));
	endfunction

	// The pixel that the block should return for one request. The pixel's
	// own alpha always goes through untouched.
	function automatic argb_t blended_pixel(input logic [lbab_pkg::ROW_BITS-1:0] r,
			input argb_t px);
		argb_t res;
		res = px;
		if (falls_in_bar(r)) begin
			res.red   = mix_channel(px.red, live_cfg.strip_color[23:16],
				live_cfg.strip_color[31:24]);
			res.green = mix_channel(px.green, live_cfg.strip_color[15:8],
				live_cfg.strip_color[31:24]);
			res.blue  = mix_channel(px.blue, live_cfg.strip_color[7:0],
				live_cfg.strip_color[31:24]);
		end
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// Rows of the directed table
	// ------------------------------------------------------------------------

	function automatic plan_step_t reg_step(input logic [lbab_pkg::WR_INDEX_BITS-1:0] index,
			input logic [lbab_pkg::WR_DATA_BITS-1:0] data);
		plan_step_t s;
		s = '0;
		s.is_write = 1'b1;
		s.index = index;
		s.data = data;
		return s;
	endfunction

	function automatic plan_step_t pixel_step(input logic [lbab_pkg::ROW_BITS-1:0] r,
			input argb_t px);
		plan_step_t s;
		s = '0;
		s.row = r;
		s.pixel = px;
		return s;
	endfunction

	function automatic plan_step_t known_step(input logic [lbab_pkg::ROW_BITS-1:0] r,
			input argb_t px, input argb_t want);
		plan_step_t s;
		s = pixel_step(r, px);
		s.typed = 1'b1;
		s.want = want;
		return s;
	endfunction

	// ------------------------------------------------------------------------
	// Driving. Every task is entered just after a rising edge and returns just
	// after one, so all inputs change by nonblocking assignment at the edge.
	// ------------------------------------------------------------------------

	// Registers are only written while nothing is in flight. The block has a
	// result for every request, so an empty queue means an empty pipeline.
	task automatic drain();
		if (start) begin
			start <= 1'b0;
		end
		while (pending_pixels.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// One write, then a cycle with the enable low so that back-to-back
	// writes never lower and raise the enable within the same time step.
	task automatic cfg_write(input logic [lbab_pkg::WR_INDEX_BITS-1:0] index,
			input logic [lbab_pkg::WR_DATA_BITS-1:0] data);
		wr_en    <= 1'b1;
		wr_index <= index;
		wr_data  <= data;
		@(posedge clk);
		wr_en <= 1'b0;
		case (index)
			lbab_pkg::REG_FRAME_HEIGHT:
				live_cfg.frame_height = data[lbab_pkg::FH_BITS-1:0];
			lbab_pkg::REG_STRIP_SIZE:
				live_cfg.strip_size = data[lbab_pkg::SS_BITS-1:0];
			lbab_pkg::REG_STRIP_COLOR:
				live_cfg.strip_color = data[lbab_pkg::SC_BITS-1:0];
			default: ;
		endcase
		writes_done++;
		@(posedge clk);
	endtask

	// Presents one pixel request and holds it until the block takes it. The
	// expectation is queued at the accepting edge, with the settings in force.
	task automatic send_pixel(input logic [lbab_pkg::ROW_BITS-1:0] r, input argb_t px,
			input bit typed, input argb_t want);
		start     <= 1'b1;
		row       <= r;
		pix_alpha <= px.alpha;
		pix_red   <= px.red;
		pix_green <= px.green;
		pix_blue  <= px.blue;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		if (falls_in_bar(r)) begin
			px_blended++;
		end else begin
			px_passed++;
		end
		pending_pixels.push_back(typed ? want : blended_pixel(r, px));
		px_sent++;
	endtask

	// Now and then the sender pauses for a gap of random length, so gaps land
	// on every stage of the pipeline. Runs without gaps stay long.
	task automatic maybe_idle(input bit allowed);
		if (allowed && $urandom_range(0, 5) == 0) begin
			if (start) begin
				start <= 1'b0;
			end
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	// ------------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------------

	task automatic note_failure(input string what, input argb_t want, input argb_t got);
		mismatches++;
		if (mismatches <= SHOWN_ERRORS) begin
			$display("%0t: %s: expected a=%02h r=%02h g=%02h b=%02h, got a=%02h r=%02h g=%02h b=%02h",
				$time, what, want.alpha, want.red, want.green, want.blue,
				got.alpha, got.red, got.green, got.blue);
		end
	endtask

	// Results cannot be held off, so every cycle with done high is taken here
	// and matched against the oldest pixel still expected.
	always @(posedge clk) begin
		if (arst_n && done) begin
			results_seen++;
			got_px = {out_alpha, out_red, out_green, out_blue};
			if (pending_pixels.size() == 0) begin
				note_failure("result with no request waiting", '0, got_px);
			end else begin
				want_px = pending_pixels.pop_front();
				if (got_px.alpha !== want_px.alpha || got_px.red !== want_px.red ||
						got_px.green !== want_px.green || got_px.blue !== want_px.blue) begin
					note_failure("pixel mismatch", want_px, got_px);
				end
			end
		end
	end

	// Watchdog: cycles in a row in which neither side moved anything.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || wr_en) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("watchdog: no progress for %0d cycles", STALL_LIMIT);
		$display("FAILURE");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------

	initial begin
		plan_step_t plan[$];
		int         fh;
		int         ss;
		int         center;
		int         edge_dist;
		int         target;
		logic [31:0] color;

		arst_n       = 1'b0;
		wr_en        = 1'b0;
		wr_index     = lbab_pkg::REG_FRAME_HEIGHT;
		wr_data      = '0;
		start        = 1'b0;
		row          = '0;
		pix_alpha    = '0;
		pix_red      = '0;
		pix_green    = '0;
		pix_blue     = '0;
		px_sent      = 0;
		px_blended   = 0;
		px_passed    = 0;
		writes_done  = 0;
		results_seen = 0;
		mismatches   = 0;
		live_cfg     = {lbab_pkg::FRAME_HEIGHT_RST, lbab_pkg::STRIP_SIZE_RST,
			lbab_pkg::STRIP_COLOR_RST};

		// Directed table. At reset the center row is 240 and a row passes
		// while its distance is below 120; the strip is opaque black, so bar
		// pixels come out black with their own alpha.
		plan = {
			known_step(12'd240,  32'hAA12_3456, 32'hAA12_3456),
			known_step(12'd0,    32'hFFFF_FFFF, 32'hFF00_0000),
			known_step(12'd4095, 32'h00FF_8001, 32'h0000_0000),
			known_step(12'd121,  32'h5AA5_3CC3, 32'h5AA5_3CC3),
			// Distance exactly at the threshold falls in the bar.
			known_step(12'd120,  32'h5AA5_3CC3, 32'h5A00_0000),
			known_step(12'd359,  32'h81FF_7F00, 32'h81FF_7F00),
			known_step(12'd360,  32'h81FF_7F00, 32'h8100_0000),
			// A fully transparent strip leaves bar pixels as they were.
			reg_step(lbab_pkg::REG_STRIP_COLOR, 32'h00FF_FFFF),
			known_step(12'd0,    32'h0102_0304, 32'h0102_0304),
			// Half-transparent strip: rounding of the blend.
			reg_step(lbab_pkg::REG_STRIP_COLOR, 32'h80FF_00FF),
			pixel_step(12'd0,    32'h0000_FF80),
			pixel_step(12'd4095, 32'hFFFF_0000),
			// Center row zero: everything is blended, and an opaque strip
			// replaces the color outright.
			reg_step(lbab_pkg::REG_STRIP_COLOR, 32'hFF12_3456),
			reg_step(lbab_pkg::REG_FRAME_HEIGHT, 32'd1),
			known_step(12'd0,    32'h7700_0000, 32'h7712_3456),
			known_step(12'd4095, 32'h01FF_FFFF, 32'h0112_3456),
			reg_step(lbab_pkg::REG_FRAME_HEIGHT, 32'd0),
			known_step(12'd0,    32'h77AB_CDEF, 32'h7712_3456),
			// Largest frame height, written with every data bit set.
			reg_step(lbab_pkg::REG_FRAME_HEIGHT, 32'hFFFF_FFFF),
			known_step(12'd4095, 32'h3355_AA99, 32'h3355_AA99),
			known_step(12'd2048, 32'h3355_AA99, 32'h3355_AA99),
			known_step(12'd2047, 32'h3355_AA99, 32'h3312_3456),
			// Zero strip size: a row passes while its distance is below c.
			reg_step(lbab_pkg::REG_FRAME_HEIGHT, 32'd4096),
			reg_step(lbab_pkg::REG_STRIP_SIZE, 32'd0),
			known_step(12'd1,    32'h1122_3344, 32'h1122_3344),
			known_step(12'd0,    32'h1122_3344, 32'h1112_3456),
			// A write to the unused index must change nothing.
			reg_step(REG_UNUSED, 32'hFFFF_FFFF),
			known_step(12'd1,    32'h1122_3344, 32'h1122_3344),
			known_step(12'd0,    32'h1122_3344, 32'h1112_3456),
			// Strip size of one: even the center row is blended.
			reg_step(lbab_pkg::REG_STRIP_SIZE, 32'h0001_0000),
			known_step(12'd2048, 32'hCCFF_FFFF, 32'hCC12_3456),
			// Strip size above one makes the pass test negative.
			reg_step(lbab_pkg::REG_STRIP_SIZE, 32'hFFFF_FFFF),
			known_step(12'd2048, 32'hCC00_0000, 32'hCC12_3456),
			reg_step(lbab_pkg::REG_STRIP_SIZE, 32'h0001_0001),
			known_step(12'd2048, 32'h0000_0000, 32'h0012_3456),
			// Smallest nonzero strip size with a partly transparent strip.
			reg_step(lbab_pkg::REG_STRIP_COLOR, 32'h40C0_3F01),
			reg_step(lbab_pkg::REG_STRIP_SIZE, 32'd1),
			pixel_step(12'd2047, 32'hFF80_7F01),
			pixel_step(12'd4095, 32'hA55A_FF00)
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_write) begin
				drain();
				cfg_write(plan[i].index, plan[i].data);
			end else begin
				send_pixel(plan[i].row, plan[i].pixel, plan[i].typed, plan[i].want);
				maybe_idle(1'b1);
			end
		end
		px_directed = px_sent;

		// Random phases. Each one picks new settings, leaning on the corner
		// values, and then streams pixels whose rows cluster around the
		// center row and around both bar edges, where the test is decided.
		for (int ph = 0; ph < PHASES; ph++) begin
			drain();

			case ($urandom_range(0, 7))
				0:       fh = 0;
				1:       fh = 1;
				2:       fh = $urandom_range(2, 3);
				3:       fh = 480;
				4:       fh = 4096;
				5:       fh = (1 << lbab_pkg::FH_BITS) - 1;
				default: fh = $urandom_range(1, 4096);
			endcase
			case ($urandom_range(0, 8))
				0:       ss = 0;
				1:       ss = 1;
				2:       ss = 32768;
				3:       ss = 65535;
				4:       ss = 65536;
				5:       ss = 65537;
				6:       ss = (1 << lbab_pkg::SS_BITS) - 1;
				default: ss = $urandom_range(0, 65536);
			endcase
			color = $urandom;
			case ($urandom_range(0, 5))
				0:       color = 32'h0000_0000;
				1:       color = 32'hFFFF_FFFF;
				2:       color[31:24] = 8'h00;
				3:       color[31:24] = 8'hFF;
				default: ;
			endcase

			// Upper data bits are random: the block must drop them.
			cfg_write(lbab_pkg::REG_FRAME_HEIGHT, ($urandom & ~32'h1FFF) | 32'(fh));
			cfg_write(lbab_pkg::REG_STRIP_SIZE, ($urandom & ~32'h1_FFFF) | 32'(ss));
			cfg_write(lbab_pkg::REG_STRIP_COLOR, color);
			if ($urandom_range(0, 2) == 0) begin
				cfg_write(REG_UNUSED, $urandom);
			end

			center = int'(live_cfg.frame_height >> 1);
			edge_dist = (live_cfg.strip_size <= 65536) ?
				int'(((longint'(lbab_pkg::ONE_FX) - longint'(live_cfg.strip_size)) *
				longint'(center)) >> lbab_pkg::FX_SHIFT) : 0;

			for (int k = 0; k < PHASE_PIXELS; k++) begin
				case ($urandom_range(0, 3))
					0:       target = center + int'($urandom_range(0, 16)) - 8;
					1:       target = center + edge_dist + int'($urandom_range(0, 4)) - 2;
					2:       target = center - edge_dist + int'($urandom_range(0, 4)) - 2;
					default: target = int'($urandom_range(0, ROW_MAX));
				endcase
				if (target < 0) begin
					target = 0;
				end
				if (target > ROW_MAX) begin
					target = ROW_MAX;
				end
				send_pixel(lbab_pkg::ROW_BITS'(target), argb_t'($urandom), 1'b0, '0);
				// The last phase runs at full rate with no gaps.
				maybe_idle(ph < PHASES - 1);
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_pixels.size() != 0) begin
			$display("%0d expected pixels never came out", pending_pixels.size());
			mismatches++;
		end

		$display("Ran %0d pixel requests (%0d from the table) and %0d register writes.",
			px_sent, px_directed, writes_done);
		$display("%0d pixels fell in a bar, %0d passed; %0d results checked, %0d errors.",
			px_blended, px_passed, results_seen, mismatches);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
